/* rtl/ffba_pkg.sv */
// Shared types and codes for the first-fit block allocator.
// Request and result items, controller commands and datapath status.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_ERASE  = 2'd1;
  localparam logic [1:0] KIND_DEFRAG = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL   = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  // Reset value of the managed cell count
  localparam logic [7:0] CELLS_RESET = 8'd128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  request_size;
    logic [15:0] erase_id;
  } ffba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_id;
  } ffba_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear;     // reset clearing pass, one cell a cycle
    logic       start;     // latch request, rewind counters
    logic       scan;      // alloc: search for a free run
    logic       fill;      // alloc: stamp the found run
    logic       erase;     // erase: free matching cells
    logic       pack;      // defragment: move used cells down
    logic       tail;      // defragment: free the tail
    logic       bump_id;   // advance the identifier counter
    logic       set_res;   // record result code
    logic [1:0] res_code;
    logic       load_out;  // move result into output register
  } ffba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic alloc_ok;    // incoming alloc passes size and counter checks
    logic erase_ok;    // incoming erase names a nonzero identifier
    logic found;       // free run of the asked size completed
    logic scan_end;    // every managed cell read and evaluated
    logic fill_last;   // fill pointer at end of run
    logic tail_done;   // tail pointer reached managed count
    logic hit;         // erase freed at least one cell
    logic out_free;    // output register can take a result
  } ffba_stat_t;

endpackage

/* rtl/ffba_dp.sv */
// Datapath of the first-fit block allocator: cell memory, scan and write
// pointers, identifier counter, size register and result register.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_dp #(
  parameter int MAX_CELLS = 128,
  parameter int ID_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ffba_pkg::ffba_cmd_t  cmd,
  output ffba_pkg::ffba_stat_t stat,
  input  ffba_pkg::ffba_req_t  req,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ffba_pkg::ffba_rsp_t  rsp
);
  import ffba_pkg::*;

  // Managed count never exceeds the 8-bit register or the memory depth
  localparam int LIM   = (MAX_CELLS < 255) ? MAX_CELLS : 255;
  localparam int CNT_W = $clog2(LIM + 1);
  localparam int AW    = $clog2(MAX_CELLS);
  localparam int EW    = (ID_BITS > 16) ? ID_BITS : 16;

  logic [ID_BITS-1:0] mem [MAX_CELLS];

  logic [7:0]         cells_in_use;
  logic [CNT_W-1:0]   count;
  logic [ID_BITS-1:0] next_id;
  ffba_req_t          req_q;
  logic [AW-1:0]      clr_ptr;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   ev_idx;
  logic               rd_vld;
  logic [ID_BITS-1:0] rd_data;
  logic [CNT_W-1:0]   run;
  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   end_idx;
  logic               hit;
  logic [1:0]         res_code;
  logic               issue;
  logic               cell_free;
  logic               match;
  logic               found;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ID_BITS-1:0] wr_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= CELLS_RESET;
    end else if (cfg_we) begin
      cells_in_use <= cfg_wdata;
    end
  end

  // Clamp managed count to memory depth
  assign count = (cells_in_use > 8'(LIM)) ? CNT_W'(LIM) : CNT_W'(cells_in_use);

  // Latch request on start
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q <= req;
    end
  end

  // Scan read pipeline: issue one address a cycle, evaluate the next cycle
  assign issue = (cmd.scan | cmd.erase | cmd.pack) && (rd_idx != count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
    ev_idx  <= rd_idx;
    rd_data <= mem[AW'(rd_idx)];
  end

  // Cell evaluation
  assign cell_free = (rd_data == '0);
  assign run_inc   = cell_free ? (run + 1'b1) : '0;
  assign match     = (EW'(rd_data) == EW'(req_q.erase_id));
  assign found     = cmd.scan && rd_vld && (8'(run_inc) == req_q.request_size);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      run <= '0;
    end else if (cmd.scan && rd_vld) begin
      run <= run_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit <= 1'b0;
    end else if (cmd.erase && rd_vld && match) begin
      hit <= 1'b1;
    end
  end

  // Write pointer: fill position, pack destination or tail position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      wr_ptr <= '0;
    end else if (found) begin
      wr_ptr  <= ev_idx + 1'b1 - CNT_W'(req_q.request_size);
      end_idx <= ev_idx;
    end else if (cmd.fill) begin
      wr_ptr <= wr_ptr + 1'b1;
    end else if (cmd.pack && rd_vld && !cell_free) begin
      wr_ptr <= wr_ptr + 1'b1;
    end else if (cmd.tail && (wr_ptr != count)) begin
      wr_ptr <= wr_ptr + 1'b1;
    end
  end

  // Clearing pass pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // Select the single memory write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(wr_ptr);
    wr_data = '0;
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr;
    end else if (cmd.fill) begin
      wr_en   = 1'b1;
      wr_data = next_id;
    end else if (cmd.erase) begin
      wr_en   = rd_vld && match;
      wr_addr = AW'(ev_idx);
    end else if (cmd.pack) begin
      wr_en   = rd_vld && !cell_free;
      wr_data = rd_data;
    end else if (cmd.tail) begin
      wr_en   = (wr_ptr != count);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Identifier counter
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= '0;
    end else if (cmd.bump_id) begin
      next_id <= next_id + 1'b1;
    end
  end

  // Result code and output register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.status   <= res_code;
      rsp.block_id <= (res_code == ST_ALLOCATED) ? 16'(next_id) : 16'd0;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.clear_done = (clr_ptr == AW'(MAX_CELLS - 1));
    stat.alloc_ok   = (req.request_size != 8'd0) && (req.request_size <= 8'(count))
                      && (next_id != '1);
    stat.erase_ok   = (req.erase_id != 16'd0);
    stat.found      = found;
    stat.scan_end   = (rd_idx == count) && !rd_vld;
    stat.fill_last  = (wr_ptr == end_idx);
    stat.tail_done  = (wr_ptr == count);
    stat.hit        = hit;
    stat.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

/* rtl/ffba_ctrl.sv */
// Controller of the first-fit block allocator: sequences the clearing pass,
// the alloc, erase and defragment phases and the result handoff.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           req_kind,
  input  ffba_pkg::ffba_stat_t stat,
  output ffba_pkg::ffba_cmd_t  cmd
);
  import ffba_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_FILL   = 8'b0000_1000,
    S_ERASE  = 8'b0001_0000,
    S_PACK   = 8'b0010_0000,
    S_TAIL   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          unique case (req_kind)
            KIND_ALLOC: begin
              if (stat.alloc_ok) begin
                state_next = S_SCAN;
              end else begin
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_NO_ROOM;
                state_next   = S_FINISH;
              end
            end
            KIND_ERASE: begin
              if (stat.erase_ok) begin
                state_next = S_ERASE;
              end else begin
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_ILLEGAL;
                state_next   = S_FINISH;
              end
            end
            KIND_DEFRAG: begin
              state_next = S_PACK;
            end
            KIND_RSVD: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_DONE;
              state_next   = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found) begin
          cmd.bump_id = 1'b1;
          state_next  = S_FILL;
        end else if (stat.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_ROOM;
          state_next   = S_FINISH;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ALLOCATED;
          state_next   = S_FINISH;
        end
      end
      S_ERASE: begin
        cmd.erase = 1'b1;
        if (stat.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = stat.hit ? ST_DONE : ST_ILLEGAL;
          state_next   = S_FINISH;
        end
      end
      S_PACK: begin
        cmd.pack = 1'b1;
        if (stat.scan_end) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail = 1'b1;
        if (stat.tail_done) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DONE;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator top level: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// Manages a row of cells in an internal memory, each free or owned by a
// block identifier. After reset the block runs a clearing pass over all
// MAX_CELLS cells, during which req_ready stays low (configuration writes
// still land). One request is handled at a time, one cell per cycle
// through the memory's single read and single write port. An alloc scans
// the N managed cells up to the first free run of request_size cells and
// then stamps that run, or scans all N when no free run is found; an erase
// scans all N, and a defragment packs used cells down, then frees the tail.
// Requests rejected by the size, identifier-counter or zero-identifier
// checks finish without a scan. The result sits in an output register, so
// the next request is accepted while an earlier result waits to be taken;
// a request that completes while that result still waits holds until it is.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
  parameter int MAX_CELLS = 128,
  parameter int ID_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ffba_pkg::ffba_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ffba_pkg::ffba_rsp_t rsp,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_kind  (req.kind),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffba_dp #(
    .MAX_CELLS (MAX_CELLS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* sim/ffba_checker.sv */
// Response checker for the first-fit block allocator: predicts each result
// from accepted request items and compares it with the response channel.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_checker #(
  parameter int MAX_CELLS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  ffba_pkg::ffba_req_t req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  ffba_pkg::ffba_rsp_t rsp,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output int                  errors,
  output int                  pending,
  output logic [15:0]         last_id
);
  import ffba_pkg::*;

  localparam logic [15:0] ID_LAST = 16'hFFFF;

  // Shadow copy of the cell store, the identifier counter and the cell count
  logic [15:0] owner [MAX_CELLS];
  logic [15:0] given_id;
  logic [7:0]  cells_cfg;
  ffba_rsp_t   replies_due [$];
  int          fail_cnt;

  // Apply one request to the shadow store and return the result it gives
  function automatic ffba_rsp_t apply_request(input ffba_req_t r);
    int        n, run, first, w, i;
    bit        hit;
    ffba_rsp_t res;
    n   = (cells_cfg > MAX_CELLS) ? MAX_CELLS : int'(cells_cfg);
    run = 0;
    first = -1;
    w   = 0;
    hit = 1'b0;
    res.status   = ST_DONE;
    res.block_id = '0;
    case (r.kind)
      KIND_ALLOC: begin
        res.status = ST_NO_ROOM;
        if (r.request_size != 0 && int'(r.request_size) <= n && given_id != ID_LAST) begin
          // find the lowest run of free cells of the asked length
          for (i = 0; i < n && first < 0; i++) begin
            run = (owner[i] == '0) ? run + 1 : 0;
            if (run == int'(r.request_size)) first = i + 1 - int'(r.request_size);
          end
          if (first >= 0) begin
            given_id = given_id + 16'd1;
            for (i = first; i < first + int'(r.request_size); i++) owner[i] = given_id;
            res.status   = ST_ALLOCATED;
            res.block_id = given_id;
          end
        end
      end
      KIND_ERASE: begin
        if (r.erase_id != '0) begin
          for (i = 0; i < n; i++) begin
            if (owner[i] == r.erase_id) begin
              owner[i] = '0;
              hit = 1'b1;
            end
          end
        end
        res.status = hit ? ST_DONE : ST_ILLEGAL;
      end
      KIND_DEFRAG: begin
        // pack used cells down in order, then free the tail
        for (i = 0; i < n; i++) begin
          if (owner[i] != '0) begin
            owner[w] = owner[i];
            w++;
          end
        end
        for (i = w; i < n; i++) owner[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    ffba_rsp_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < MAX_CELLS; i++) owner[i] = '0;
      given_id  = '0;
      cells_cfg = CELLS_RESET;
      replies_due.delete();
      fail_cnt  = 0;
    end else begin
      if (cfg_we) cells_cfg = cfg_wdata;
      // compare a taken result with the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result item: status %0d, block_id %0d", rsp.status, rsp.block_id);
          fail_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_cnt++;
          end
          if (rsp.block_id !== want.block_id) begin
            $error("block_id: expected %0d, got %0d", want.block_id, rsp.block_id);
            fail_cnt++;
          end
        end
      end
      // predict the result of an accepted request item
      if (req_valid && req_ready) replies_due.push_back(apply_request(req));
    end
    errors  <= fail_cnt;
    pending <= replies_due.size();
    last_id <= given_id;
  end

endmodule

/* sim/testbench.sv */
// Top of the first-fit block allocator bench: clock, reset, request and
// config stimulus, response back-pressure, watchdog and verdict.
// Depends on ffba_pkg, first_fit_block_allocator and ffba_checker.
`timescale 1ns / 1ps

module testbench;
  import ffba_pkg::*;

  localparam int MAX_CELLS   = 128;
  localparam int WATCH_LIMIT = 4000;
  localparam int DRAIN       = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  ffba_req_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  ffba_rsp_t   rsp;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  int          errors, pending;
  logic [15:0] last_id;
  int          send_idle = 23;
  int          recv_idle = 78;
  int          cur_cells = 128;
  int          quiet     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_block_allocator #(
    .MAX_CELLS(MAX_CELLS),
    .ID_BITS  (16)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  ffba_checker #(
    .MAX_CELLS(MAX_CELLS)
  ) alloc_check (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending),
    .last_id  (last_id)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    rsp_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // End the run when no item moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic ffba_req_t make_alloc(input int size);
    ffba_req_t r;
    r.kind         = KIND_ALLOC;
    r.request_size = 8'(size);
    r.erase_id     = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  function automatic ffba_req_t make_erase(input int id);
    ffba_req_t r;
    r.kind         = KIND_ERASE;
    r.request_size = 8'($urandom_range(255));
    r.erase_id     = 16'(id);
    return r;
  endfunction

  function automatic ffba_req_t make_other(input logic [1:0] kind);
    ffba_req_t r;
    r.kind         = kind;
    r.request_size = 8'($urandom_range(255));
    r.erase_id     = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  // Mostly small allocs and erases of recently given identifiers
  function automatic ffba_req_t random_request();
    int eff, few, pick, lo;
    eff  = (cur_cells > MAX_CELLS) ? MAX_CELLS : cur_cells;
    few  = (eff / 8 < 1) ? 1 : ((eff / 8 > 8) ? 8 : eff / 8);
    lo   = (int'(last_id) > 24) ? int'(last_id) - 24 : 1;
    pick = $urandom_range(99);
    if (pick < 45) begin
      pick = $urandom_range(99);
      if (pick < 5) return make_alloc(0);
      if (pick < 12) return make_alloc($urandom_range(255));
      if (pick < 20) return make_alloc($urandom_range((eff < 1) ? 1 : eff, 1));
      return make_alloc($urandom_range(few, 1));
    end
    if (pick < 78) begin
      pick = $urandom_range(99);
      if (pick < 6) return make_erase(0);
      if (pick < 14) return make_erase($urandom_range(16'hFFFF));
      return make_erase($urandom_range(int'(last_id) + 1, lo));
    end
    if (pick < 90) return make_other(KIND_DEFRAG);
    return make_other(KIND_RSVD);
  endfunction

  // Offer one request item, with a random gap first, and hold until taken
  task automatic send(input ffba_req_t item);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_cells(input int cells);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= 8'(cells);
    cur_cells = cells;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int cells, input int count);
    set_cells(cells);
    repeat (count) send(random_request());
  endtask

  initial begin
    ffba_req_t opening [$];

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_cells(128);

    // Directed: size limits, full store, illegal erases, holes and packing
    opening.push_back(make_alloc(0));
    opening.push_back(make_alloc(129));
    opening.push_back(make_alloc(255));
    opening.push_back(make_alloc(1));
    opening.push_back(make_alloc(128));
    opening.push_back(make_alloc(127));
    opening.push_back(make_alloc(1));
    opening.push_back(make_erase(0));
    opening.push_back(make_erase(16'hFFFF));
    opening.push_back(make_erase(1));
    opening.push_back(make_erase(1));
    opening.push_back(make_other(KIND_DEFRAG));
    opening.push_back(make_alloc(1));
    opening.push_back(make_erase(2));
    opening.push_back(make_alloc(3));
    opening.push_back(make_alloc(5));
    opening.push_back(make_alloc(2));
    opening.push_back(make_erase(5));
    opening.push_back(make_alloc(6));
    opening.push_back(make_alloc(4));
    opening.push_back(make_other(KIND_RSVD));
    opening.push_back(make_other(KIND_DEFRAG));
    opening.push_back(make_alloc(128));
    foreach (opening[i]) send(opening[i]);

    // Random traffic over several cell counts and idling modes
    run_random(128, 280);
    run_random(1, 90);
    run_random(255, 200);
    send_idle = 78;
    recv_idle = 23;
    run_random(0, 40);
    run_random(17, 200);
    run_random(128, 220);
    send_idle = 0;
    recv_idle = 0;
    run_random(64, 200);
    run_random(128, 170);

    settle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* first_fit_block_allocator.f */
rtl/ffba_pkg.sv
rtl/ffba_dp.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
sim/ffba_checker.sv
sim/testbench.sv
